/* rtl/weighted_knn_regressor_assert.svh */
// Assertion macros used by the checker file.
`ifndef WEIGHTED_KNN_REGRESSOR_ASSERT_SVH
`define WEIGHTED_KNN_REGRESSOR_ASSERT_SVH
`define WKNN_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define WKNN_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* rtl/wknn_pkg.sv */
package wknn_pkg;
	localparam int FEAT_W = 16;
	localparam int DIST_W = 24;
	localparam int WGT_W = 33;
	localparam int HIST_DEPTH = 256;
	localparam int K_MAX = 16;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [9:0] EPS_Q816 = 10'd655;
	// Reciprocal of 100 scaled by 2^37, exact for any 32-bit dividend.
	localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [4:0] NEIGHBOR_RESET = 5'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] feat_avg;
		logic [15:0] feat_spread;
		logic signed [15:0] feat_trend;
		logic [15:0] feat_minutes;
		logic [15:0] outcome;
	} req_t;

	typedef struct packed {
		logic [15:0] prediction;
		logic [1:0] status;
		logic [8:0] stored_count;
	} rsp_t;

	// Control between sequencer and the iterative unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} itu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} itu_sts_t;
endpackage

/* rtl/wknn_if.sv */
interface wknn_req_if;
	logic valid;
	logic ready;
	wknn_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wknn_rsp_if;
	logic valid;
	logic ready;
	wknn_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/wknn_itu.sv */
module wknn_itu (
	input logic clk,
	input logic arst_n,
	input wknn_pkg::itu_ctl_t ctl,
	input logic [63:0] op_a,
	input logic [32:0] op_b,
	output wknn_pkg::itu_sts_t sts,
	output logic [63:0] result
);
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic is_div_q;
	logic [63:0] num_q;
	logic [32:0] den_q;
	logic [65:0] rem_q;
	logic [63:0] res_q;
	logic [65:0] rem_sh;
	logic [65:0] trial;
	logic ok;

	always_comb begin
		if (is_div_q) begin
			rem_sh = {rem_q[64:0], num_q[63]};
			trial = {33'd0, den_q};
		end else begin
			rem_sh = {rem_q[63:0], num_q[63:62]};
			trial = {res_q[63:0], 2'b01};
		end
		ok = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.is_div ? 7'd64 : 7'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			is_div_q <= ctl.is_div;
			num_q <= op_a;
			den_q <= op_b;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			num_q <= is_div_q ? {num_q[62:0], 1'b0} : {num_q[61:0], 2'b00};
			rem_q <= ok ? rem_sh - trial : rem_sh;
			res_q <= {res_q[62:0], ok};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result = res_q;
endmodule

/* rtl/weighted_knn_regressor.sv */
// Channel | Dir | Payload
// req     | in  | req_type, feat_avg, feat_spread, feat_trend, feat_minutes, outcome
// rsp     | out | prediction, status, stored_count
// cfg     | in  | APB, neighbor_count at address 0
// Clear, append and a query on an empty store give their result the cycle after
// the request is taken, so such requests can be taken every second cycle.
// A query on N entries with K neighbors uses the shared square-root and divide unit
// for a root per entry, a divide per neighbor weight and a final weighted divide.
// Reset clears control state and sets neighbor_count to 5; the stores are
// undefined until written. A result waits in the output register until taken.
module weighted_knn_regressor (
	input logic clk,
	input logic arst_n,
	wknn_req_if.sink req,
	wknn_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int HW = $clog2(wknn_pkg::HIST_DEPTH);
	localparam int CW = $clog2(wknn_pkg::HIST_DEPTH + 1);
	localparam int KW = $clog2(wknn_pkg::K_MAX);
	localparam int KC = $clog2(wknn_pkg::K_MAX + 1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RD = 10'b0000000010,
		S_DIFF = 10'b0000000100,
		S_SUM = 10'b0000001000,
		S_SQRT = 10'b0000010000,
		S_INS = 10'b0000100000,
		S_WRD = 10'b0001000000,
		S_DIV = 10'b0010000000,
		S_ACC = 10'b0100000000,
		S_FDIV = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [4:0] ncount_q;
	logic [CW-1:0] total_q;
	wknn_pkg::req_t req_q;
	wknn_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic [63:0] feat_mem [wknn_pkg::HIST_DEPTH];
	logic [15:0] out_mem [wknn_pkg::HIST_DEPTH];
	logic [63:0] feat_rd_q;
	logic [15:0] out_rd_q;
	logic [CW-1:0] idx_q;
	logic [KC-1:0] k_q;
	logic [KC-1:0] filled_q;
	logic [KC-1:0] acc_q;
	logic [wknn_pkg::DIST_W-1:0] bd_q [wknn_pkg::K_MAX];
	logic [HW-1:0] bi_q [wknn_pkg::K_MAX];
	logic [33:0] sq_a_s1, sq_s_s1, sq_t_s1;
	logic [31:0] sq_m_s1;
	logic [63:0] m100_prod;
	logic [33:0] sq_sum;
	logic [wknn_pkg::DIST_W-1:0] dist_q;
	logic [wknn_pkg::WGT_W-1:0] w_q;
	logic [52:0] wsum_q;
	logic [wknn_pkg::WGT_W+KW:0] wtot_q;
	wknn_pkg::itu_ctl_t ctl;
	wknn_pkg::itu_sts_t sts;
	logic [63:0] op_a;
	logic [32:0] op_b;
	logic [63:0] itu_res;
	logic [16:0] da, ds, dt, dm;
	logic [KC-1:0] kk;
	logic [KW:0] pos;

	wknn_itu u_itu (.clk(clk), .arst_n(arst_n), .ctl(ctl), .op_a(op_a), .op_b(op_b),
		.sts(sts), .result(itu_res));

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {27'd0, ncount_q} : 32'd0;
	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	assign m100_prod = 64'(sq_m_s1) * 64'(wknn_pkg::DIV100_MAGIC);
	assign sq_sum = sq_a_s1 + sq_s_s1 + sq_t_s1 + 34'(m100_prod[63:37]);

	always_comb begin
		logic signed [16:0] ta, tb;
		ta = {1'b0, req_q.feat_avg};
		tb = {1'b0, feat_rd_q[15:0]};
		da = 17'(ta > tb ? ta - tb : tb - ta);
		ta = {1'b0, req_q.feat_spread};
		tb = {1'b0, feat_rd_q[31:16]};
		ds = 17'(ta > tb ? ta - tb : tb - ta);
		ta = {req_q.feat_trend[15], req_q.feat_trend};
		tb = {feat_rd_q[47], feat_rd_q[47:32]};
		dt = 17'(ta > tb ? ta - tb : tb - ta);
		ta = {1'b0, req_q.feat_minutes};
		tb = {1'b0, feat_rd_q[63:48]};
		dm = 17'(ta > tb ? ta - tb : tb - ta);
		kk = KC'(ncount_q == 5'd0 ? 1 : (int'(ncount_q) > wknn_pkg::K_MAX ?
			wknn_pkg::K_MAX : int'(ncount_q)));
		if (int'(kk) > int'(total_q))
			kk = KC'(total_q);
		pos = '0;
		for (int i = 0; i < wknn_pkg::K_MAX; i++)
			if (KC'(i) < filled_q && bd_q[i] <= dist_q)
				pos = (KW + 1)'(i + 1);
	end

	always_comb begin
		ctl.start = 1'b0;
		ctl.is_div = 1'b0;
		op_a = {14'd0, sq_sum, 16'd0};
		op_b = '0;
		if (state_q == S_SUM)
			ctl.start = 1'b1;
		if (state_q == S_WRD) begin
			ctl.start = 1'b1;
			ctl.is_div = 1'b1;
			op_a = 64'h1_0000_0000;
			op_b = 33'(bd_q[acc_q[KW-1:0]]) + 33'(wknn_pkg::EPS_Q816);
		end
		if (state_q == S_ACC && acc_q == filled_q && wtot_q != '0) begin
			ctl.start = 1'b1;
			ctl.is_div = 1'b1;
			op_a = 64'(wsum_q);
			op_b = 33'(wtot_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid && req.ready &&
				req.data.req_type == wknn_pkg::REQ_APPEND &&
				int'(total_q) < wknn_pkg::HIST_DEPTH) begin
			feat_mem[total_q[HW-1:0]] <= {req.data.feat_minutes, req.data.feat_trend,
				req.data.feat_spread, req.data.feat_avg};
			out_mem[total_q[HW-1:0]] <= req.data.outcome;
		end
		feat_rd_q <= feat_mem[idx_q[HW-1:0]];
		out_rd_q <= out_mem[bi_q[acc_q[KW-1:0]]];
		sq_a_s1 <= (34'(da) * 34'(da)) << 1;
		sq_s_s1 <= 34'(ds) * 34'(ds);
		sq_t_s1 <= 34'(dt) * 34'(dt);
		sq_m_s1 <= 32'(dm) * 32'(dm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ncount_q <= wknn_pkg::NEIGHBOR_RESET;
			total_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == 2'd0)
				ncount_q <= pwdata[4:0];
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						idx_q <= '0;
						filled_q <= '0;
						k_q <= kk;
						case (req.data.req_type)
							wknn_pkg::REQ_CLEAR: begin
								total_q <= '0;
								rsp_q <= '{prediction: 16'd0, status: wknn_pkg::ST_DONE,
									stored_count: 9'd0};
								rsp_valid_q <= 1'b1;
							end
							wknn_pkg::REQ_APPEND: begin
								if (int'(total_q) < wknn_pkg::HIST_DEPTH) begin
									total_q <= total_q + 1'b1;
									rsp_q <= '{prediction: 16'd0, status: wknn_pkg::ST_DONE,
										stored_count: 9'(total_q + 1'b1)};
								end else begin
									rsp_q <= '{prediction: 16'd0, status: wknn_pkg::ST_FULL,
										stored_count: 9'(total_q)};
								end
								rsp_valid_q <= 1'b1;
							end
							wknn_pkg::REQ_QUERY: begin
								if (total_q == '0) begin
									rsp_q <= '{prediction: req.data.feat_avg,
										status: wknn_pkg::ST_EMPTY, stored_count: 9'(total_q)};
									rsp_valid_q <= 1'b1;
								end else begin
									rsp_q <= '{prediction: 16'd0, status: wknn_pkg::ST_DONE,
										stored_count: 9'(total_q)};
									state_q <= S_RD;
								end
							end
							default: begin
								rsp_q <= '{prediction: 16'd0, status: wknn_pkg::ST_DONE,
									stored_count: 9'(total_q)};
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD: state_q <= S_DIFF;
				S_DIFF: state_q <= S_SUM;
				S_SUM: state_q <= S_SQRT;
				S_SQRT: begin
					if (sts.done) begin
						dist_q <= (itu_res[63:24] != '0) ? wknn_pkg::DIST_MAX : itu_res[23:0];
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (pos < (KW + 1)'(k_q)) begin
						for (int j = wknn_pkg::K_MAX - 1; j > 0; j--)
							if ((KW + 1)'(j) > pos) begin
								bd_q[j] <= bd_q[j-1];
								bi_q[j] <= bi_q[j-1];
							end
						bd_q[pos[KW-1:0]] <= dist_q;
						bi_q[pos[KW-1:0]] <= idx_q[HW-1:0];
						if (filled_q < k_q)
							filled_q <= filled_q + 1'b1;
					end
					if (idx_q + 1'b1 == total_q) begin
						acc_q <= '0;
						wsum_q <= '0;
						wtot_q <= '0;
						state_q <= S_WRD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_WRD: state_q <= S_DIV;
				S_DIV: begin
					if (sts.done) begin
						w_q <= itu_res[32:0];
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (acc_q == filled_q) begin
						if (wtot_q == '0) begin
							rsp_q.prediction <= req_q.feat_avg;
							rsp_valid_q <= 1'b1;
							state_q <= S_IDLE;
						end else
							state_q <= S_FDIV;
					end else begin
						wsum_q <= wsum_q + 53'(out_rd_q) * 53'(w_q);
						wtot_q <= wtot_q + (wknn_pkg::WGT_W + KW + 1)'(w_q);
						acc_q <= acc_q + 1'b1;
						state_q <= (acc_q + 1'b1 == filled_q) ? S_ACC : S_WRD;
					end
				end
				S_FDIV: begin
					if (sts.done) begin
						rsp_q.prediction <= itu_res[15:0];
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/wknn_checker.sv */
`include "weighted_knn_regressor_assert.svh"
module wknn_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [1:0] req_type,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] status,
	input logic [15:0] prediction,
	input logic [8:0] stored_count
);
	`WKNN_ASSERT_NXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(prediction))
	`WKNN_ASSERT_IMP(a_excl, clk, arst_n, rsp_valid, !req_ready)
	`WKNN_ASSERT_IMP(a_full, clk, arst_n, rsp_valid && status == wknn_pkg::ST_FULL, stored_count == 9'(wknn_pkg::HIST_DEPTH))
	`WKNN_ASSERT_NXT(a_clr, clk, arst_n, req_valid && req_ready && req_type == wknn_pkg::REQ_CLEAR,
		stored_count == 9'd0)
endmodule

bind weighted_knn_regressor wknn_checker u_chk (.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .req_type(req.data.req_type),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.data.status),
	.prediction(rsp.data.prediction), .stored_count(rsp.data.stored_count));

/* verif/weighted_knn_regressor_tb.sv */
module weighted_knn_regressor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	class knn_scoreboard;
		logic [63:0] feats [wknn_pkg::HIST_DEPTH];
		logic [15:0] outs [wknn_pkg::HIST_DEPTH];
		int unsigned total;
		int unsigned k_reg;
		wknn_pkg::rsp_t pending [$];
		int errors;

		function new();
			total = 0;
			k_reg = 5;
			errors = 0;
		endfunction

		function logic [63:0] isqrt(logic [63:0] v);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [63:0] dist_of(wknn_pkg::req_t q, logic [63:0] e);
			longint da, ds, dt, dm;
			logic [63:0] s, d;
			da = longint'(q.feat_avg) - longint'(e[15:0]);
			ds = longint'(q.feat_spread) - longint'(e[31:16]);
			dt = longint'(q.feat_trend) - longint'($signed(e[47:32]));
			dm = longint'(q.feat_minutes) - longint'(e[63:48]);
			s = 2 * da * da + ds * ds + dt * dt + (dm * dm) / 100;
			d = isqrt(s << 16);
			return (d > 64'hFFFFFF) ? 64'hFFFFFF : d;
		endfunction

		function void note_request(wknn_pkg::req_t q);
			wknn_pkg::rsp_t r;
			int unsigned k, filled, p, j;
			logic [63:0] bd [wknn_pkg::K_MAX];
			int unsigned bi [wknn_pkg::K_MAX];
			logic [63:0] d, w, wsum, wtot;
			r = '0;
			if (q.req_type == wknn_pkg::REQ_CLEAR) begin
				total = 0;
			end else if (q.req_type == wknn_pkg::REQ_APPEND) begin
				if (total >= wknn_pkg::HIST_DEPTH) begin
					r.status = wknn_pkg::ST_FULL;
				end else begin
					feats[total] = {q.feat_minutes, q.feat_trend, q.feat_spread, q.feat_avg};
					outs[total] = q.outcome;
					total++;
				end
			end else if (q.req_type == wknn_pkg::REQ_QUERY) begin
				if (total == 0) begin
					r.prediction = q.feat_avg;
					r.status = wknn_pkg::ST_EMPTY;
				end else begin
					k = k_reg;
					if (k < 1) k = 1;
					if (k > wknn_pkg::K_MAX) k = wknn_pkg::K_MAX;
					if (k > total) k = total;
					filled = 0;
					for (int i = 0; i < total; i++) begin
						d = dist_of(q, feats[i]);
						p = filled;
						while (p > 0 && bd[p-1] > d) p--;
						if (p < k) begin
							j = (filled < k) ? filled : k - 1;
							while (j > p) begin
								bd[j] = bd[j-1];
								bi[j] = bi[j-1];
								j--;
							end
							bd[p] = d;
							bi[p] = i;
							if (filled < k) filled++;
						end
					end
					wsum = 0;
					wtot = 0;
					for (int i = 0; i < filled; i++) begin
						w = (64'd1 << 32) / (bd[i] + 655);
						wsum += 64'(outs[bi[i]]) * w;
						wtot += w;
					end
					r.prediction = (wtot != 0) ? 16'(wsum / wtot) : q.feat_avg;
				end
			end
			r.stored_count = 9'(total);
			pending.insert(pending.size(), r);
		endfunction

		function void check_response(wknn_pkg::rsp_t a);
			wknn_pkg::rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", a);
				return;
			end
			e = pending.pop_front();
			if (a.prediction !== e.prediction || a.status !== e.status ||
				a.stored_count !== e.stored_count) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected pred %h st %0d cnt %0d, got pred %h st %0d cnt %0d",
						e.prediction, e.status, e.stored_count,
						a.prediction, a.status, a.stored_count);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	wknn_req_if req_ch();
	wknn_rsp_if rsp_ch();
	knn_scoreboard sb = new();
	bit hold_off = 0;

	initial begin
		req_ch.valid = 0;
		req_ch.data = '0;
		rsp_ch.ready = 0;
	end

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	weighted_knn_regressor dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	task automatic write_k(logic [4:0] k);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= 2'd0;
		pwdata <= 32'(k);
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.k_reg = k;
	endtask

	task automatic send_request(wknn_pkg::req_t q, bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			req_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(q);
	endtask

	task automatic drain();
		req_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic wknn_pkg::req_t rand_req(logic [1:0] t);
		wknn_pkg::req_t q;
		q.req_type = t;
		q.feat_avg = 16'($urandom);
		q.feat_spread = 16'($urandom);
		q.feat_trend = 16'($urandom);
		q.feat_minutes = 16'($urandom);
		q.outcome = 16'($urandom);
		if ($urandom_range(0, 1)) begin
			q.feat_avg = 16'($urandom_range(16'h0800, 16'h1800));
			q.feat_spread = 16'($urandom_range(0, 16'h0400));
			q.feat_trend = 16'($urandom_range(0, 16'h0400)) - 16'h0200;
		end
		return q;
	endfunction

	function automatic wknn_pkg::req_t fixed_req(logic [1:0] t, logic [15:0] v,
		logic [15:0] oc);
		wknn_pkg::req_t q;
		q.req_type = t;
		q.feat_avg = v;
		q.feat_spread = v;
		q.feat_trend = v;
		q.feat_minutes = v;
		q.outcome = oc;
		return q;
	endfunction

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
	end

	initial begin
		int g;
		@(posedge clk);
		forever begin
			if (hold_off) begin
				rsp_ch.ready <= 0;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end else begin
				g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				if (g > 0) begin
					rsp_ch.ready <= 0;
					repeat (g) @(posedge clk);
				end
				rsp_ch.ready <= 1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int g;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'hFFFF, 0), 0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'h0000, 16'h0000), 0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'hFFFF, 16'hFFFF), 0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'h8000, 16'h1234), 0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'h7FFF, 16'h4321), 0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'h7FFF, 16'h5555), 0);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'h7FFF, 0), 0);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'h0000, 0), 0);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'hFFFF, 0), 0);
		send_request(fixed_req(2'd3, 16'hFFFF, 16'hFFFF), 0);
		send_request(fixed_req(wknn_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF), 0);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'h1234, 0), 0);
		drain();
		write_k(5'd0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'h0100, 16'h0A00), 0);
		send_request(fixed_req(wknn_pkg::REQ_APPEND, 16'h0100, 16'h0B00), 0);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'h0100, 0), 0);
		drain();
		write_k(5'd31);
		send_request(fixed_req(wknn_pkg::REQ_QUERY, 16'h0100, 0), 0);
		drain();
		write_k(5'd16);
		for (int i = 0; i < 260; i++) begin
			if (i == 20) hold_off = 1;
			send_request(rand_req(i % 40 == 39 ? wknn_pkg::REQ_QUERY : wknn_pkg::REQ_APPEND),
				i < 30);
		end
		send_request(rand_req(wknn_pkg::REQ_QUERY), 0);
		send_request(rand_req(wknn_pkg::REQ_APPEND), 0);
		drain();
		write_k(5'd1);
		send_request(rand_req(wknn_pkg::REQ_QUERY), 0);
		send_request(rand_req(wknn_pkg::REQ_CLEAR), 0);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			write_k(5'($urandom_range(0, 31)));
			for (int i = 0; i < 10; i++) begin
				g = $urandom_range(0, 9);
				send_request(rand_req(g < 6 ? wknn_pkg::REQ_APPEND : g < 9 ?
					wknn_pkg::REQ_QUERY : 2'($urandom_range(0, 3))), 0);
			end
			drain();
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
